@@ rtl/core/turn_signal_hazard_flasher_top_assert.svh @@
// Assertion macros shared by the flasher RTL.
// Both macros use the clock and reset of the module that invokes them.
`ifndef TURN_SIGNAL_HAZARD_FLASHER_TOP_ASSERT_SVH
`define TURN_SIGNAL_HAZARD_FLASHER_TOP_ASSERT_SVH

`ifndef SYNTH

// cond must hold at every clock edge outside reset
`define TSF_ASSERT_HOLD(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("flasher assertion failed");

// when ante holds, cons must hold in the same cycle
`define TSF_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("flasher assertion failed");

`else

`define TSF_ASSERT_HOLD(label, cond)
`define TSF_ASSERT_IMPLY(label, ante, cons)

`endif

`endif

@@ rtl/core/tsf_pkg.sv @@
package tsf_pkg;

   // Fixed widths of the configuration registers
   localparam int THR_WIDTH  = 8;
   localparam int INTV_WIDTH = 16;
   localparam int CSR_IDX_WIDTH  = 8;
   localparam int CSR_DATA_WIDTH = 16;

   // Register reset values
   localparam logic [THR_WIDTH-1:0]  THR_RESET  = 8'd20;
   localparam logic [INTV_WIDTH-1:0] INTV_RESET = 16'd333;

   // Register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_IDX_THRESHOLD = 8'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_IDX_INTERVAL  = 8'd1;

   // Flasher modes
   typedef enum logic [1:0] {
      MODE_OFF    = 2'd0,
      MODE_RIGHT  = 2'd1,
      MODE_LEFT   = 2'd2,
      MODE_HAZARD = 2'd3
   } mode_type;

   // One flag per button, bit 0 right, bit 1 left, bit 2 hazard
   typedef struct packed {
      logic hazard;
      logic left;
      logic right;
   } btn_set_type;

endpackage

@@ rtl/core/turn_signal_hazard_flasher_top.sv @@
// Turn-signal and hazard flasher with debounced active-low buttons. Each request
// is one scan tick and yields exactly one response with the lamp levels and mode
// after that tick. A request is taken each cycle that req_tready is high: the tick
// is worked out in one pass through the press counters and mode logic, and the state
// registers themselves are the response register. A response not yet taken holds
// req_tready low until rsp_tready rises, so throughput is one tick per cycle
// whenever the response side keeps up. Register writes (index 0 debounce
// threshold, index 1 blink interval) are always accepted; other indexes are
// ignored.
module turn_signal_hazard_flasher_top
   import tsf_pkg::*;
#(
   parameter int COUNT_WIDTH = 8,
   parameter int TIMER_WIDTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,   // right_button, left_button, hazard_button
   // response channel
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [7:0]                rsp_tdata,   // right_lamp, left_lamp, mode[1:0]
   // register writes
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [CSR_DATA_WIDTH-1:0] csr_data
);

   logic                  req_fire;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [THR_WIDTH-1:0]  thr_ff;
   logic [INTV_WIDTH-1:0] intv_ff;
   btn_set_type           edges;
   logic [1:0]            lamps;
   mode_type              mode;

   // Handshake: take a request when the response slot is free or draining
   assign req_tready   = !rsp_valid_ff || rsp_tready;
   assign req_fire     = req_tvalid && req_tready;
   assign rsp_valid_in = req_fire || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff  <= THR_RESET;
         intv_ff <= INTV_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_IDX_THRESHOLD) begin
            thr_ff <= csr_data[THR_WIDTH-1:0];
         end else if (csr_index == CSR_IDX_INTERVAL) begin
            intv_ff <= csr_data[INTV_WIDTH-1:0];
         end
      end
   end

   tsf_debounce #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_debounce (
      .clock     (clock),
      .reset     (reset),
      .step      (req_fire),
      .btn_n     (req_tdata[2:0]),
      .threshold (thr_ff),
      .edges     (edges)
   );

   tsf_flasher #(
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_flasher (
      .clock    (clock),
      .reset    (reset),
      .step     (req_fire),
      .edges    (edges),
      .interval (intv_ff),
      .lamps    (lamps),
      .mode     (mode)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, mode, lamps[1], lamps[0]};

endmodule

@@ rtl/core/tsf_debounce.sv @@
module tsf_debounce
   import tsf_pkg::*;
#(
   parameter int COUNT_WIDTH = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,       // request accepted this cycle
   input  logic [2:0]           btn_n,      // right, left, hazard; low = pressed
   input  logic [THR_WIDTH-1:0] threshold,
   output btn_set_type          edges       // rising edges of debounced levels
);

   localparam int CMP_W = (COUNT_WIDTH > THR_WIDTH) ? COUNT_WIDTH : THR_WIDTH;

   logic [COUNT_WIDTH-1:0] cnt_ff [3];
   logic [COUNT_WIDTH-1:0] cnt_in [3];
   logic [2:0]             deb_ff;
   logic [2:0]             deb_in;

   // Press counters: clear on release, saturate at all ones
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (btn_n[i]) begin
            cnt_in[i] = '0;
         end else if (&cnt_ff[i]) begin
            cnt_in[i] = cnt_ff[i];
         end else begin
            cnt_in[i] = cnt_ff[i] + 1'b1;
         end
         deb_in[i] = CMP_W'(cnt_in[i]) > CMP_W'(threshold);
      end
   end

   assign edges = btn_set_type'(deb_in & ~deb_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            cnt_ff[i] <= '0;
         end
         deb_ff <= '0;
      end else if (step) begin
         for (int i = 0; i < 3; i++) begin
            cnt_ff[i] <= cnt_in[i];
         end
         deb_ff <= deb_in;
      end
   end

endmodule

@@ rtl/core/tsf_flasher.sv @@
`include "turn_signal_hazard_flasher_top_assert.svh"

module tsf_flasher
   import tsf_pkg::*;
#(
   parameter int TIMER_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  btn_set_type           edges,
   input  logic [INTV_WIDTH-1:0] interval,
   output logic [1:0]            lamps,     // bit 0 right, bit 1 left
   output mode_type              mode
);

   localparam int CMP_W = (TIMER_WIDTH > INTV_WIDTH) ? TIMER_WIDTH : INTV_WIDTH;

   mode_type               mode_ff, mode_in, mode_pick;
   logic [1:0]             lamp_ff, lamp_in, sel;
   logic [TIMER_WIDTH-1:0] timer_ff, timer_in, timer_inc;

   // Lamps that blink in a given mode
   function automatic logic [1:0] blink_mask(mode_type m);
      case (m)
         MODE_RIGHT:  blink_mask = 2'b01;
         MODE_LEFT:   blink_mask = 2'b10;
         MODE_HAZARD: blink_mask = 2'b11;
         default:     blink_mask = 2'b00;
      endcase
   endfunction

   // Mode selection, hazard first, then right, then left
   always_comb begin
      if (edges.hazard) begin
         mode_pick = (mode_ff == MODE_HAZARD) ? MODE_OFF : MODE_HAZARD;
      end else if (edges.right) begin
         mode_pick = (mode_ff == MODE_RIGHT) ? MODE_OFF : MODE_RIGHT;
      end else if (edges.left) begin
         mode_pick = (mode_ff == MODE_LEFT) ? MODE_OFF : MODE_LEFT;
      end else begin
         mode_pick = mode_ff;
      end
   end

   // Saturating tick timer
   assign timer_inc = (&timer_ff) ? timer_ff : timer_ff + 1'b1;
   assign sel       = blink_mask(mode_ff);

   // Mode change restarts blinking, otherwise toggle once the interval is passed
   always_comb begin
      mode_in  = mode_ff;
      lamp_in  = lamp_ff;
      timer_in = timer_inc;
      if (mode_pick != mode_ff) begin
         mode_in  = mode_pick;
         lamp_in  = 2'b11;
         timer_in = '0;
      end else if (CMP_W'(timer_inc) > CMP_W'(interval)) begin
         lamp_in  = (lamp_ff ^ sel) | ~sel;
         timer_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_OFF;
         lamp_ff  <= 2'b11;
         timer_ff <= '0;
      end else if (step) begin
         mode_ff  <= mode_in;
         lamp_ff  <= lamp_in;
         timer_ff <= timer_in;
      end
   end

   assign lamps = lamp_ff;
   assign mode  = mode_ff;

   // A lamp outside the selected side is always held high
   `TSF_ASSERT_IMPLY(a_right_holds_left, mode_ff == MODE_RIGHT, lamp_ff[1])
   `TSF_ASSERT_IMPLY(a_left_holds_right, mode_ff == MODE_LEFT, lamp_ff[0])
   `TSF_ASSERT_IMPLY(a_off_both_high, mode_ff == MODE_OFF, lamp_ff == 2'b11)
   // Hazard lamps start together and toggle together
   `TSF_ASSERT_IMPLY(a_hazard_in_phase, mode_ff == MODE_HAZARD, lamp_ff[0] == lamp_ff[1])
   // A mode change leaves both lamps high and the timer restarted
   `TSF_ASSERT_IMPLY(a_change_restart, !$past(reset) && mode_ff != $past(mode_ff), lamp_ff == 2'b11 && timer_ff == '0)

endmodule
